// ----- design/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the sensor sample classifier: status codes,
// per-channel physical limits in Q11.8 LSBs, lane flags and the result word.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // status codes of one classified frame
    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_DUPE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SPIKE = 2'd3;

    // configuration register indexes
    localparam logic [7:0] REG_DUP_TOL = 8'd0;
    localparam logic [7:0] REG_PERIOD  = 8'd1;

    localparam int MAX_LANES = 8;

    typedef logic [15:0] t_limit;

    // upper limit and largest step of each channel (lower limit is zero)
    localparam t_limit LIM_MAX [MAX_LANES] = '{
        16'd10240, 16'd25600, 16'd25600, 16'd5120, 16'd3584, 16'd1280, 16'd0, 16'd0
    };
    localparam t_limit LIM_STEP [MAX_LANES] = '{
        16'd1280, 16'd5120, 16'd15360, 16'd768, 16'd256, 16'd128, 16'd0, 16'd0
    };

    // what one lane found for its channel
    typedef struct packed {
        logic within_tol;
        logic range_fail;
        logic step_fail;
    } t_lane_flags;

    // result word, status in the lowest bits
    typedef struct packed {
        logic       analysis_due;
        logic [8:0] ring_fill;
        logic [7:0] ring_slot;
        logic [2:0] failing_channel;
        logic [1:0] status;
    } t_result;

endpackage

// ----- design/ssc_lane.sv -----
// ----------------------------------------------------------------------------
// ssc_lane
// Checks one channel: distance to the base value against the duplicate
// tolerance and the step limit, and the value against its physical range.
// ----------------------------------------------------------------------------
module ssc_lane #(
    parameter int VALUE_WIDTH = 20,
    parameter int LANE        = 0
) (
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [VALUE_WIDTH-1:0] i_base,
    input  logic        [7:0]             i_tolerance,
    output ssc_pkg::t_lane_flags          o_flags
);

    localparam int DW = VALUE_WIDTH + 1;
    localparam int CW = (DW > 16) ? DW : 16;

    logic [DW-1:0] w_diff;
    logic [DW-1:0] w_abs;
    logic [CW-1:0] w_abs_ext;
    logic [CW-1:0] w_mag_ext;

    // absolute difference to the base, one bit wider than the value
    assign w_diff    = {i_value[VALUE_WIDTH-1], i_value} - {i_base[VALUE_WIDTH-1], i_base};
    assign w_abs     = w_diff[DW-1] ? (~w_diff + 1'b1) : w_diff;
    assign w_abs_ext = CW'(w_abs);
    assign w_mag_ext = CW'(i_value[VALUE_WIDTH-2:0]);

    // compares against tolerance, step and range
    assign o_flags.within_tol = (w_abs_ext <= CW'(i_tolerance));
    assign o_flags.step_fail  = (w_abs_ext > CW'(ssc_pkg::LIM_STEP[LANE]));
    assign o_flags.range_fail = i_value[VALUE_WIDTH-1] ||
                                (w_mag_ext > CW'(ssc_pkg::LIM_MAX[LANE]));

endmodule

// ----- design/ssc_merge.sv -----
// ----------------------------------------------------------------------------
// ssc_merge
// Combines the lane flags into the frame status and the first failing
// channel, range before step within a channel.
// ----------------------------------------------------------------------------
module ssc_merge #(
    parameter int CHANNELS = 6
) (
    input  ssc_pkg::t_lane_flags i_flags [CHANNELS],
    input  logic                 i_base_present,
    input  logic                 i_seq_match,
    output logic [1:0]           o_status,
    output logic [2:0]           o_failing_channel
);

    logic w_same;

    // all channels within tolerance of the base
    always_comb begin
        w_same = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (!i_flags[i].within_tol) begin
                w_same = 1'b0;
            end
        end
    end

    // duplicate first, then first channel out of range or stepping too far
    always_comb begin
        logic found;
        found             = 1'b0;
        o_status          = ssc_pkg::ST_VALID;
        o_failing_channel = 3'(CHANNELS);
        if (i_base_present && (i_seq_match || w_same)) begin
            o_status = ssc_pkg::ST_DUPE;
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (!found) begin
                    if (i_flags[i].range_fail) begin
                        found             = 1'b1;
                        o_status          = ssc_pkg::ST_RANGE;
                        o_failing_channel = 3'(i);
                    end else if (i_base_present && i_flags[i].step_fail) begin
                        found             = 1'b1;
                        o_status          = ssc_pkg::ST_SPIKE;
                        o_failing_channel = 3'(i);
                    end
                end
            end
        end
    end

endmodule

// ----- design/ssc_out_buf.sv -----
// ----------------------------------------------------------------------------
// ssc_out_buf
// Output register with a skid stage, so a new word is taken while a finished
// result still waits for the receiver.
// ----------------------------------------------------------------------------
module ssc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ssc_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output ssc_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    ssc_pkg::t_result r_out_data;
    ssc_pkg::t_result r_skid_data;
    logic             w_push;
    logic             w_pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign w_push  = i_valid && !r_skid_valid;
    assign w_pop   = r_out_valid && i_ready;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                r_out_valid  <= r_skid_valid || w_push;
                r_skid_valid <= 1'b0;
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_push) begin
                r_out_data <= i_data;
            end
        end else if (w_push) begin
            r_skid_data <= i_data;
        end
    end

endmodule

// ----- design/sensor_sample_classifier_top.sv -----
// ----------------------------------------------------------------------------
// sensor_sample_classifier_top
// Classifies sensor frames as valid, duplicate, out of range or spike.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) takes one frame per word: CHANNELS readings of
//   VALUE_WIDTH bits (signed Q11.8), then the 32-bit sequence number and
//   the 32-bit timestamp. Master stream (o_m_*) returns one result word per
//   frame: status, failing channel, ring slot, ring fill, analysis due.
//   Configuration is a plain write port: index 0 duplicate tolerance,
//   index 1 analysis period; other indexes are ignored. Write it only while
//   no frame is in flight.
//   All channels are checked in parallel lanes and merged in the cycle the
//   frame is accepted, which is also when the base frame, ring head, fill
//   count and trigger time update. The result reaches the master side from
//   the output register; one frame per cycle while the receiver takes them.
//   An output register plus a skid stage hold up to two results, so one
//   more frame is taken while the receiver stalls; tready then drops.
//   Reset (synchronous, active low) clears the base, ring counters, trigger
//   time and registers (tolerance 0, period 60).
// ----------------------------------------------------------------------------
module sensor_sample_classifier_top #(
    parameter int CHANNELS    = 6,
    parameter int RING_DEPTH  = 256,
    parameter int VALUE_WIDTH = 20
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // config write port
    input  logic                                        i_cfg_we,
    input  logic [7:0]                                  i_cfg_addr,
    input  logic [15:0]                                 i_cfg_wdata,
    // slave stream
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // channel 0 .. CHANNELS-1, sequence_number, timestamp, zero pad
    input  logic [((CHANNELS*VALUE_WIDTH+64+7)/8)*8-1:0] i_s_tdata,
    // master stream
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // status, failing_channel, ring_slot, ring_fill, analysis_due, zero pad
    output logic [23:0]                                 o_m_tdata
);

    localparam int HW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNTW = $clog2(RING_DEPTH + 1);
    localparam int SEQ_LO = CHANNELS * VALUE_WIDTH;
    localparam int TS_LO  = SEQ_LO + 32;

    logic signed [VALUE_WIDTH-1:0] w_value [CHANNELS];
    logic [31:0]                   w_seq;
    logic [31:0]                   w_ts;
    logic                          w_accept;

    logic [7:0]                    r_dup_tol;
    logic [15:0]                   r_period;
    logic signed [VALUE_WIDTH-1:0] r_base [CHANNELS];
    logic [31:0]                   r_base_seq;
    logic                          r_base_present;
    logic [HW-1:0]                 r_head;
    logic [CNTW-1:0]               r_count;
    logic [31:0]                   r_last_trig;

    logic [HW-1:0]                 n_head;
    logic [CNTW-1:0]               n_count;
    logic                          w_due;

    ssc_pkg::t_lane_flags          w_flags [CHANNELS];
    logic [1:0]                    w_status;
    logic [2:0]                    w_fail;
    logic                          w_seq_match;
    logic [HW+7:0]                 w_slot_ext;
    logic [CNTW+8:0]               w_fill_ext;
    ssc_pkg::t_result              w_result;
    ssc_pkg::t_result              w_out;
    logic                          w_buf_ready;

    assign o_s_tready = w_buf_ready;
    assign w_accept   = i_s_tvalid && w_buf_ready;
    assign w_seq      = i_s_tdata[SEQ_LO +: 32];
    assign w_ts       = i_s_tdata[TS_LO +: 32];

    // one lane per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        assign w_value[g] = i_s_tdata[g*VALUE_WIDTH +: VALUE_WIDTH];
        ssc_lane #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .LANE        (g)
        ) u_lane (
            .i_value     (w_value[g]),
            .i_base      (r_base[g]),
            .i_tolerance (r_dup_tol),
            .o_flags     (w_flags[g])
        );
    end

    // sequence number given and equal to the base
    assign w_seq_match = !w_seq[31] && (w_seq == r_base_seq);

    ssc_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_flags           (w_flags),
        .i_base_present    (r_base_present),
        .i_seq_match       (w_seq_match),
        .o_status          (w_status),
        .o_failing_channel (w_fail)
    );

    // ring head and fill count after a valid frame
    assign n_head  = (r_head == HW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_count = (r_count == CNTW'(RING_DEPTH)) ? r_count : r_count + 1'b1;

    // analysis trigger, 32-bit wrapping sum
    assign w_due = (r_last_trig == 32'd0) || (w_ts >= (r_last_trig + 32'(r_period)));

    // result word
    assign w_slot_ext = {8'd0, r_head};
    assign w_fill_ext = (w_status == ssc_pkg::ST_VALID) ? {9'd0, n_count} : {9'd0, r_count};
    assign w_result.status          = w_status;
    assign w_result.failing_channel = w_fail;
    assign w_result.ring_slot       = w_slot_ext[7:0];
    assign w_result.ring_fill       = w_fill_ext[8:0];
    assign w_result.analysis_due    = w_due;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup_tol <= 8'd0;
            r_period  <= 16'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ssc_pkg::REG_DUP_TOL: r_dup_tol <= i_cfg_wdata[7:0];
                ssc_pkg::REG_PERIOD:  r_period  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // base frame, ring counters and trigger time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_present <= 1'b0;
            r_base_seq     <= 32'd0;
            r_head         <= '0;
            r_count        <= '0;
            r_last_trig    <= 32'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_base[i] <= '0;
            end
        end else if (w_accept) begin
            if (w_status == ssc_pkg::ST_VALID) begin
                r_base_present <= 1'b1;
                r_base_seq     <= w_seq;
                r_head         <= n_head;
                r_count        <= n_count;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_base[i] <= w_value[i];
                end
            end
            if (w_due) begin
                r_last_trig <= w_ts;
            end
        end
    end

    ssc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (w_buf_ready),
        .i_data  (w_result),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata = {1'b0, w_out};

endmodule

// ----- tb/sensor_sample_classifier_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_sample_classifier_top_tb
// Drives sensor frames into the classifier and checks every result word
// against hand-set values or a model of the base frame, ring counters and trigger time.
// A short table of hand-picked frames comes first, then random phases under
// several tolerance and period settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module sensor_sample_classifier_top_tb;

    typedef ssc_pkg::t_result t_result;

    // status codes and register indexes from the shared package
    localparam logic [1:0] ST_VALID    = ssc_pkg::ST_VALID;
    localparam logic [1:0] ST_DUPE     = ssc_pkg::ST_DUPE;
    localparam logic [1:0] ST_RANGE    = ssc_pkg::ST_RANGE;
    localparam logic [1:0] ST_SPIKE    = ssc_pkg::ST_SPIKE;
    localparam logic [7:0] REG_DUP_TOL = ssc_pkg::REG_DUP_TOL;
    localparam logic [7:0] REG_PERIOD  = ssc_pkg::REG_PERIOD;

    localparam int CH        = 6;
    localparam int DATA_W    = 184;
    localparam int LIMIT     = 300000;
    localparam int RING_SIZE = 256;

    localparam logic [2:0] CH_NONE       = 3'd6;
    localparam logic [7:0] REG_UNUSED_LO = 8'd2;
    localparam logic [7:0] REG_UNUSED_HI = 8'hFF;

    // physical limits per channel in Q11.8 LSBs, lower limit is zero
    localparam int CH_MAX  [CH] = '{10240, 25600, 25600, 5120, 3584, 1280};
    localparam int CH_STEP [CH] = '{1280, 5120, 15360, 768, 256, 128};

    // in-range reading per channel
    localparam int M0 = 5120;
    localparam int M1 = 12800;
    localparam int M2 = 12800;
    localparam int M3 = 2560;
    localparam int M4 = 1792;
    localparam int M5 = 512;

    // input word, channel 0 in the lowest bits
    typedef struct packed {
        logic [31:0]      ts;
        logic [31:0]      seq;
        logic [5:0][19:0] chan;
    } t_frame;

    typedef struct {
        t_frame  f;
        bit      typed;
        t_result want;
    } t_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [7:0]          i_cfg_addr  = '0;
    logic [15:0]         i_cfg_wdata = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [DATA_W-1:0]   i_s_tdata   = '0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b1;
    logic [23:0]         o_m_tdata;

    // model state
    int          base_val [CH];
    logic [31:0] base_seq   = '0;
    bit          base_ok    = 1'b0;
    logic [7:0]  ring_head  = '0;
    logic [8:0]  ring_count = '0;
    logic [31:0] last_trig  = '0;
    logic [7:0]  dup_tol    = 8'd0;
    logic [15:0] period     = 16'd60;

    t_result     pending_results [$];
    t_row        vectors [$];

    // stimulus and bookkeeping
    int          gap_pct    = 25;
    int          stall_pct  = 25;
    int          stall_left = 0;
    int          seq_ctr    = 100;
    logic [31:0] ts_now     = 32'd100;
    int          errors     = 0;
    int          cycles     = 0;
    int          frames     = 0;
    int          words      = 0;
    int          due_seen   = 0;
    int          fill_peak  = 0;
    int          status_seen [4];
    t_result     got_res;
    t_result     want_res;

    sensor_sample_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d words still pending", $time,
                     pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // classify one accepted frame and advance the local state
    function automatic t_result classify(t_frame f);
        t_result     r;
        int          v [CH];
        int          d;
        bit          same;
        bit          due;
        logic [31:0] due_at;
        r.status          = ST_VALID;
        r.failing_channel = CH_NONE;
        r.ring_slot       = ring_head;
        for (int i = 0; i < CH; i++) v[i] = int'($signed(f.chan[i]));
        // duplicate by sequence number or by values within tolerance
        if (base_ok) begin
            same = 1'b1;
            for (int i = 0; i < CH; i++) begin
                d = v[i] - base_val[i];
                if (d < 0) d = -d;
                if (d > int'(dup_tol)) same = 1'b0;
            end
            if ((!f.seq[31] && f.seq == base_seq) || same) r.status = ST_DUPE;
        end
        // range then step, channel by channel
        if (r.status == ST_VALID) begin
            for (int i = 0; i < CH; i++) begin
                d = v[i] - base_val[i];
                if (d < 0) d = -d;
                if (v[i] < 0 || v[i] > CH_MAX[i]) begin
                    r.status          = ST_RANGE;
                    r.failing_channel = 3'(i);
                    break;
                end
                if (base_ok && d > CH_STEP[i]) begin
                    r.status          = ST_SPIKE;
                    r.failing_channel = 3'(i);
                    break;
                end
            end
        end
        // a valid frame becomes the base and takes a ring slot
        if (r.status == ST_VALID) begin
            for (int i = 0; i < CH; i++) base_val[i] = v[i];
            base_seq  = f.seq;
            base_ok   = 1'b1;
            ring_head = ring_head + 8'd1;
            if (ring_count < RING_SIZE) ring_count = ring_count + 9'd1;
        end
        r.ring_fill = ring_count;
        // periodic trigger with wrapping deadline
        due_at = last_trig + {16'd0, period};
        due    = (last_trig == 32'd0) || (f.ts >= due_at);
        if (due) last_trig = f.ts;
        r.analysis_due = due;
        return r;
    endfunction

    function automatic t_frame mk(int c0, int c1, int c2, int c3, int c4, int c5,
                                  logic [31:0] sq, logic [31:0] ts);
        t_frame f;
        f.chan[0] = c0[19:0];
        f.chan[1] = c1[19:0];
        f.chan[2] = c2[19:0];
        f.chan[3] = c3[19:0];
        f.chan[4] = c4[19:0];
        f.chan[5] = c5[19:0];
        f.seq     = sq;
        f.ts      = ts;
        return f;
    endfunction

    task automatic known(t_frame f, logic [1:0] st, logic [2:0] fc, logic [7:0] sl,
                         logic [8:0] fl, logic due);
        t_row row;
        row.f                    = f;
        row.typed                = 1'b1;
        row.want.status          = st;
        row.want.failing_channel = fc;
        row.want.ring_slot       = sl;
        row.want.ring_fill       = fl;
        row.want.analysis_due    = due;
        vectors.push_back(row);
    endtask

    task automatic predicted(t_frame f);
        t_row row;
        row.f     = f;
        row.typed = 1'b0;
        row.want  = '0;
        vectors.push_back(row);
    endtask

    // random frame, mostly well-formed steps around the current base
    function automatic t_frame make_frame();
        t_frame f;
        int     kind;
        int     v;
        int     lo;
        int     hi;
        int     k;
        int     b;
        int     t;
        int     r;
        kind = $urandom_range(0, 99);
        t    = int'(dup_tol);
        for (int i = 0; i < CH; i++) begin
            if (!base_ok) begin
                v = $urandom_range(0, CH_MAX[i]);
            end else begin
                lo = base_val[i] - CH_STEP[i];
                hi = base_val[i] + CH_STEP[i];
                if (lo < 0) lo = 0;
                if (hi > CH_MAX[i]) hi = CH_MAX[i];
                v = lo + int'($urandom_range(0, hi - lo));
            end
            if (kind >= 55 && kind < 65 && base_ok)
                v = base_val[i] + int'($urandom_range(0, 2 * t)) - t;
            if (kind >= 80 && kind < 90) v = $urandom;
            f.chan[i] = v[19:0];
        end
        // push one channel onto an edge of its range or step
        if (kind >= 70 && kind < 80) begin
            k = $urandom_range(0, CH - 1);
            b = base_ok ? base_val[k] : 0;
            case ($urandom_range(0, 6))
                0: v = -1;
                1: v = 0;
                2: v = CH_MAX[k];
                3: v = CH_MAX[k] + 1;
                4: v = b + CH_STEP[k];
                5: v = b + CH_STEP[k] + 1;
                default: v = b - CH_STEP[k] - 1;
            endcase
            f.chan[k] = v[19:0];
        end
        // sequence number
        if (kind >= 65 && kind < 70 && base_ok) begin
            f.seq = base_seq;
        end else if (kind >= 80 && kind < 90) begin
            f.seq = $urandom;
        end else if (kind >= 90) begin
            f.seq = {1'b1, 31'($urandom)};
        end else begin
            seq_ctr++;
            f.seq = 32'(seq_ctr);
        end
        // timestamp, mostly moving forward, sometimes onto the deadline
        r = $urandom_range(0, 99);
        if (r < 2) ts_now = $urandom;
        else if (r < 4) ts_now = last_trig + {16'd0, period} - 32'd1;
        else if (r < 7) ts_now = last_trig + {16'd0, period};
        else ts_now = ts_now + $urandom_range(0, 2 * int'(period) + 2);
        f.ts = ts_now;
        return f;
    endfunction

    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // offer one frame, predict it once taken
    task automatic send_frame(t_frame f, bit typed, t_result want);
        t_result p;
        i_s_tdata  <= f;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        p = classify(f);
        pending_results.push_back(typed ? want : p);
        frames++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == REG_DUP_TOL) dup_tol = val[7:0];
        else if (idx == REG_PERIOD) period = val;
    endtask

    task automatic run_phase(int tol, int per, int pct, int n_frames, int pause_at);
        drain();
        write_reg(REG_DUP_TOL, 16'(tol));
        write_reg(REG_PERIOD, 16'(per));
        i_cfg_we  <= 1'b0;
        gap_pct   = pct;
        stall_pct = pct;
        for (int n = 0; n < n_frames; n++) begin
            sender_gap();
            send_frame(make_frame(), 1'b0, '0);
            if (n == pause_at) drain();
        end
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // receiver stalls in short bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 4);
        i_m_tready <= (stall_left == 0);
    end

    // compare each result word with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_res = o_m_tdata[22:0];
            words++;
            status_seen[got_res.status]++;
            if (got_res.analysis_due) due_seen++;
            if (int'(got_res.ring_fill) > fill_peak) fill_peak = int'(got_res.ring_fill);
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: word %h with no frame pending, expected none, actual %h",
                         $time, o_m_tdata, o_m_tdata);
            end else begin
                want_res = pending_results.pop_front();
                compare_field("status", int'(want_res.status), int'(got_res.status));
                compare_field("failing_channel", int'(want_res.failing_channel),
                              int'(got_res.failing_channel));
                compare_field("ring_slot", int'(want_res.ring_slot),
                              int'(got_res.ring_slot));
                compare_field("ring_fill", int'(want_res.ring_fill),
                              int'(got_res.ring_fill));
                compare_field("analysis_due", int'(want_res.analysis_due),
                              int'(got_res.analysis_due));
            end
        end
    end

    initial begin
        for (int i = 0; i < CH; i++) base_val[i] = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;

        // directed frames, default tolerance 0 and period 60
        known(mk(M0, M1, M2, M3, M4, M5, 32'd10, 32'd1000), ST_VALID, CH_NONE, 8'd0, 9'd1, 1'b1);
        // same sequence number, different values
        known(mk(M0 + 1, M1, M2, M3, M4, M5, 32'd10, 32'd1010), ST_DUPE, CH_NONE, 8'd1, 9'd1,
              1'b0);
        // no sequence number, identical values
        known(mk(M0, M1, M2, M3, M4, M5, 32'hFFFF_FFFF, 32'd1020), ST_DUPE, CH_NONE, 8'd1, 9'd1,
              1'b0);
        // no sequence number, one LSB off, stored with its negative sequence
        known(mk(M0 + 1, M1, M2, M3, M4, M5, 32'hFFFF_FFFF, 32'd1030), ST_VALID, CH_NONE, 8'd1,
              9'd2, 1'b0);
        // negative against negative base never matches; deadline reached exactly
        known(mk(M0, M1, M2, M3, M4, M5, 32'hFFFF_FFFF, 32'd1060), ST_VALID, CH_NONE, 8'd2,
              9'd3, 1'b1);
        known(mk(-1, M1, M2, M3, M4, M5, 32'd11, 32'd1070), ST_RANGE, 3'd0, 8'd3, 9'd3, 1'b0);
        known(mk(10241, M1, M2, M3, M4, M5, 32'd12, 32'd1080), ST_RANGE, 3'd0, 8'd3, 9'd3,
              1'b0);
        known(mk(M0, M1, M2, M3, M4, 1281, 32'd13, 32'd1090), ST_RANGE, 3'd5, 8'd3, 9'd3, 1'b0);
        known(mk(M0, M1, M2, -524288, M4, M5, 32'd14, 32'd1100), ST_RANGE, 3'd3, 8'd3, 9'd3,
              1'b0);
        known(mk(M0, M1, 524287, M3, M4, M5, 32'd14, 32'd1110), ST_RANGE, 3'd2, 8'd3, 9'd3,
              1'b0);
        known(mk(M0, M1 + 5121, M2, M3, M4, M5, 32'd15, 32'd1120), ST_SPIKE, 3'd1, 8'd3, 9'd3,
              1'b1);
        known(mk(M0, M1 + 5120, M2, M3, M4, M5, 32'd16, 32'd1130), ST_VALID, CH_NONE, 8'd3,
              9'd4, 1'b0);
        // spike on channel 0 wins over range on channel 1
        known(mk(M0 + 1281, 25601, M2, M3, M4, M5, 32'd17, 32'd1140), ST_SPIKE, 3'd0, 8'd4,
              9'd4, 1'b0);
        known(mk(M0, 12799, M2, 5121, M4, M5, 32'd18, 32'd1150), ST_SPIKE, 3'd1, 8'd4, 9'd4,
              1'b0);
        // matching sequence number beats out-of-range values
        known(mk(524287, 524287, 524287, 524287, 524287, 524287, 32'd16, 32'd1160), ST_DUPE,
              CH_NONE, 8'd4, 9'd4, 1'b0);
        predicted(mk(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'd1170));
        predicted(mk(10240, 25600, 25600, 5120, 3584, 1280, 32'h8000_0000, 32'd1180));
        // largest allowed steps, timestamp at the top
        predicted(mk(6400, 12800, 0, 3328, 1536, 640, 32'd19, 32'hFFFF_FFFF));
        predicted(mk(6400, 12800, 0, 3328, 1536, 640, 32'd20, 32'd10));
        predicted(mk(6399, 12800, 0, 3328, 1536, 640, 32'd21, 32'd59));
        predicted(mk(6398, 12800, 0, 3328, 1536, 640, 32'd22, 32'hFFFF_FFC4));
        // trigger at time zero, then the next frame triggers again
        predicted(mk(6397, 12800, 0, 3328, 1536, 640, 32'd23, 32'd0));
        predicted(mk(6396, 12800, 0, 3328, 1536, 640, 32'd24, 32'd5));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vectors[i]) begin
            sender_gap();
            send_frame(vectors[i].f, vectors[i].typed, vectors[i].want);
        end

        // masked and unmapped register writes before the first phase
        drain();
        write_reg(REG_DUP_TOL, 16'hFF00);
        write_reg(REG_UNUSED_LO, 16'h1234);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        run_phase(0, 60, 20, 285, -1);
        run_phase(255, 1, 30, 285, 120);
        run_phase(3, 65535, 15, 285, -1);
        run_phase($urandom_range(1, 254), 0, 25, 285, -1);
        run_phase($urandom_range(0, 255), $urandom_range(1, 65535), 0, 285, -1);

        drain();
        repeat (4) @(posedge i_clk);
        $display("%0d frames sent, %0d result words checked: %0d valid, %0d duplicate,",
                 frames, words, status_seen[ST_VALID], status_seen[ST_DUPE]);
        $display("%0d out of range, %0d spike, %0d analysis pulses, ring fill peak %0d",
                 status_seen[ST_RANGE], status_seen[ST_SPIKE], due_seen, fill_peak);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
